@@ rtl/core/rx_fifo_with_idle_frame_detect_unit_defines.svh @@
// Assertion macros shared by the receive FIFO RTL.
`ifndef RX_FIFO_WITH_IDLE_FRAME_DETECT_UNIT_DEFINES_SVH
`define RX_FIFO_WITH_IDLE_FRAME_DETECT_UNIT_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define RXF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RXF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/rxf_pkg.sv @@
// Types and constants of the receive FIFO with idle frame detection.
package rxf_pkg;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 8;

    localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 16'd30;
    localparam logic [TIME_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_FLUSH = 3'd2,
        ACT_TICK  = 3'd3,
        ACT_ACK   = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-transfer result of the control unit, minus the popped byte
    typedef struct packed {
        t_status              status;
        logic [LEVEL_W-1:0]   fill_level;
        logic                 frame_ready;
        logic                 pop_ok;
    } t_ctrl_res;

endpackage

@@ rtl/core/rxf_ifs.sv @@
// Valid/ready channel interfaces for input actions and results.
interface rxf_in_if;
    logic                           valid;
    logic                           ready;
    logic [rxf_pkg::ACTION_W-1:0]   action;
    logic [rxf_pkg::BYTE_W-1:0]     byte_in;
    logic [rxf_pkg::TIME_W-1:0]     elapsed;

    modport source (output valid, action, byte_in, elapsed, input ready);
    modport sink   (input valid, action, byte_in, elapsed, output ready);
endinterface

interface rxf_out_if;
    logic                           valid;
    logic                           ready;
    logic [rxf_pkg::STATUS_W-1:0]   status;
    logic [rxf_pkg::BYTE_W-1:0]     byte_out;
    logic [rxf_pkg::LEVEL_W-1:0]    fill_level;
    logic                           frame_ready;

    modport source (output valid, status, byte_out, fill_level, frame_ready, input ready);
    modport sink   (input valid, status, byte_out, fill_level, frame_ready, output ready);
endinterface

@@ rtl/core/rxf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module rxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rxf_ctrl.sv @@
// Pointer, fill level and idle-gap frame detection control.
`include "rx_fifo_with_idle_frame_detect_unit_defines.svh"

module rxf_ctrl #(
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_acc,
    input  logic [rxf_pkg::ACTION_W-1:0]   i_action,
    input  logic [rxf_pkg::BYTE_W-1:0]     i_byte_in,
    input  logic [rxf_pkg::TIME_W-1:0]     i_elapsed,
    input  logic                           i_cfg_we,
    input  logic [rxf_pkg::TIME_W-1:0]     i_cfg_wdata,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [rxf_pkg::BYTE_W-1:0]     o_ram_wdata,
    output logic                           o_ram_re,
    output logic [AW-1:0]                  o_ram_raddr,
    output rxf_pkg::t_ctrl_res             o_res
);

    // Pointers run modulo twice the depth
    localparam int PW = $clog2(2 * DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   SPAN     = (PW + 1)'(2 * DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] PTR_DEP  = PW'(DEPTH);
    localparam logic [LW-1:0] LVL_FULL = LW'(DEPTH);

    logic [PW-1:0]                r_wp, r_rp, n_wp, n_rp;
    logic [LW-1:0]                r_last, n_last;
    logic [rxf_pkg::TIME_W-1:0]   r_count, n_count;
    logic                         r_flag, n_flag;
    logic [rxf_pkg::TIME_W-1:0]   r_limit;

    logic [LW-1:0]                lvl_now, lvl_new;
    logic                         full, empty;
    logic [rxf_pkg::TIME_W:0]     sum;
    logic [rxf_pkg::TIME_W-1:0]   sum_sat;
    logic [LW+7:0]                lvl_ext;
    rxf_pkg::t_status             status;
    logic                         push_ok, pop_ok;

    function automatic logic [LW-1:0] level_of(logic [PW-1:0] wp, logic [PW-1:0] rp);
        logic [PW:0] d;
        d = {1'b0, wp} + ((wp < rp) ? SPAN : '0) - {1'b0, rp};
        return d[LW-1:0];
    endfunction

    function automatic logic [AW-1:0] index_of(logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p >= PTR_DEP) ? p - PTR_DEP : p;
        return q[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign lvl_now = level_of(r_wp, r_rp);
    assign full    = (lvl_now == LVL_FULL);
    assign empty   = (lvl_now == '0);

    // Saturating idle accumulation
    assign sum     = {1'b0, r_count} + {1'b0, i_elapsed};
    assign sum_sat = sum[rxf_pkg::TIME_W] ? rxf_pkg::COUNT_MAX : sum[rxf_pkg::TIME_W-1:0];

    // Action decode and next state
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_last  = r_last;
        n_count = r_count;
        n_flag  = r_flag;
        status  = rxf_pkg::ST_OK;
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        unique case (i_action)
            rxf_pkg::ACT_PUSH: begin
                if (full) begin
                    status = rxf_pkg::ST_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_wp    = ptr_inc(r_wp);
                end
            end
            rxf_pkg::ACT_POP: begin
                if (empty) begin
                    status = rxf_pkg::ST_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    n_rp   = ptr_inc(r_rp);
                end
            end
            rxf_pkg::ACT_FLUSH: begin
                n_rp = r_wp;
            end
            rxf_pkg::ACT_TICK: begin
                if (empty) begin
                    n_last = '0;
                end else if (lvl_now != r_last) begin
                    n_last  = lvl_now;
                    n_count = '0;
                end else if (r_count < r_limit) begin
                    n_count = sum_sat;
                    if (sum_sat >= r_limit) begin
                        n_flag = 1'b1;
                    end
                end
            end
            rxf_pkg::ACT_ACK: begin
                n_flag = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_last  <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_acc) begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_last  <= n_last;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    // Idle limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rxf_pkg::IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Store access
    assign o_ram_we    = i_acc && push_ok;
    assign o_ram_waddr = index_of(r_wp);
    assign o_ram_wdata = i_byte_in;
    assign o_ram_re    = i_acc && pop_ok;
    assign o_ram_raddr = index_of(r_rp);

    // Result after the action, level cut to the output width
    assign lvl_new           = level_of(n_wp, n_rp);
    assign lvl_ext           = {8'b0, lvl_new};
    assign o_res.status      = status;
    assign o_res.fill_level  = lvl_ext[7:0];
    assign o_res.frame_ready = n_flag;
    assign o_res.pop_ok      = pop_ok;

    `RXF_ASSERT(a_level_bound, (lvl_now <= LVL_FULL), "fill level above depth")
    `RXF_ASSERT(a_full_push_hold, (i_acc && i_action == rxf_pkg::ACT_PUSH && full) |=> $stable(r_wp), "write pointer moved on dropped push")
    `RXF_ASSERT(a_flag_by_tick, $rose(r_flag) |-> $past(i_acc && i_action == rxf_pkg::ACT_TICK), "frame flag set outside a tick")

endmodule

@@ rtl/core/rx_fifo_with_idle_frame_detect_unit.sv @@
// A result passes stage 1 and then the output register, where it is held until taken.
// Throughput: one action per cycle while results are taken; state updates at the transfer.
// A pop reads the byte store through its registered read port; the data lands in the stage before the output.
// Reset (synchronous, active low) clears pointers, idle state, frame flag and both stages,
// and sets the idle limit to 30; the byte store itself is not cleared.
`include "rx_fifo_with_idle_frame_detect_unit_defines.svh"

module rx_fifo_with_idle_frame_detect_unit #(
    parameter int DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rxf_in_if.sink                         i_in,
    rxf_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [rxf_pkg::TIME_W-1:0]     i_cfg_wdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                           acc;
    logic                           s1_move;
    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [rxf_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;
    rxf_pkg::t_ctrl_res             res;

    logic                           r_s1_valid;
    rxf_pkg::t_ctrl_res             r_s1_res;
    logic                           r_out_valid;
    logic [rxf_pkg::STATUS_W-1:0]   r_out_status;
    logic [rxf_pkg::BYTE_W-1:0]     r_out_byte;
    logic [rxf_pkg::LEVEL_W-1:0]    r_out_level;
    logic                           r_out_frame;

    // Handshake: stage 1 drains into the output register when that register is empty or its result is taken
    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign acc        = i_in.valid && i_in.ready;

    rxf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_action    (i_in.action),
        .i_byte_in   (i_in.byte_in),
        .i_elapsed   (i_in.elapsed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_res       (res)
    );

    rxf_ram #(.WIDTH(rxf_pkg::BYTE_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage 1: waits for store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res <= res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_res.status;
            r_out_byte   <= r_s1_res.pop_ok ? ram_rdata : '0;
            r_out_level  <= r_s1_res.fill_level;
            r_out_frame  <= r_s1_res.frame_ready;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.byte_out    = r_out_byte;
    assign o_out.fill_level  = r_out_level;
    assign o_out.frame_ready = r_out_frame;

    `RXF_ASSERT(a_pop_to_s1, (acc && res.pop_ok) |=> (r_s1_valid && r_s1_res.pop_ok), "pop lost before stage 1")
    `RXF_ASSERT(a_s1_hold, (r_s1_valid && !s1_move) |=> r_s1_valid, "stage 1 dropped while stalled")
    `RXF_ASSERT_ALWAYS(a_rst_empty, (!i_rst_n) |=> (!r_s1_valid && !r_out_valid), "pipeline not cleared by reset")

endmodule

@@ dv/tb_rx_fifo_with_idle_frame_detect_unit.sv @@
// Self-checking testbench for the receive FIFO with idle frame detection.
module tb_rx_fifo_with_idle_frame_detect_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_DEPTH  = 128;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          N_DIR       = 26;

    typedef struct packed {
        rxf_pkg::t_status                 status;
        logic [rxf_pkg::BYTE_W-1:0]       byte_out;
        logic [rxf_pkg::LEVEL_W-1:0]      fill_level;
        logic                             frame_ready;
    } t_rx_result;

    localparam t_rx_result NO_RES = '0;

    // One directed row: action, payload, elapsed time, repeat count, optional fixed result
    typedef struct {
        rxf_pkg::t_action                 act;
        logic [rxf_pkg::BYTE_W-1:0]       data;
        logic [rxf_pkg::TIME_W-1:0]       el;
        int unsigned                      reps;
        bit                               typed;
        t_rx_result                       res;
    } t_dir_row;

    // Reset limit of 30 holds for the whole table
    t_dir_row dir_rows [N_DIR] = '{
        '{rxf_pkg::ACT_POP,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_EMPTY, 8'h00, 8'd0,   1'b0}},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd0,   1'b0}},
        '{rxf_pkg::ACT_PUSH,  8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd1,   1'b0}},
        '{rxf_pkg::ACT_PUSH,  8'hFF, 16'hFFFF, 1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd2,   1'b0}},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd5,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd29,   1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd1,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'hFFFF, 1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_ACK,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd2,   1'b0}},
        '{rxf_pkg::ACT_POP,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd1,   1'b0}},
        '{rxf_pkg::ACT_POP,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'hFF, 8'd0,   1'b0}},
        '{rxf_pkg::ACT_POP,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_EMPTY, 8'h00, 8'd0,   1'b0}},
        '{rxf_pkg::ACT_PUSH,  8'hA5, 16'd0,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_PUSH,  8'h5A, 16'd0,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd0,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'hFFFF, 1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_FLUSH, 8'h00, 16'd0,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd7,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_ACK,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd0,   1'b0}},
        '{rxf_pkg::ACT_PUSH,  8'h00, 16'd0,    128, 1'b0, NO_RES},
        '{rxf_pkg::ACT_PUSH,  8'h3C, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_FULL,  8'h00, 8'd128, 1'b0}},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd3,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_TICK,  8'h00, 16'd40,   1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_POP,   8'h00, 16'd0,    128, 1'b0, NO_RES},
        '{rxf_pkg::ACT_FLUSH, 8'h00, 16'd0,    1,   1'b0, NO_RES},
        '{rxf_pkg::ACT_ACK,   8'h00, 16'd0,    1,   1'b1,
          '{rxf_pkg::ST_OK,    8'h00, 8'd0,   1'b0}}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [rxf_pkg::TIME_W-1:0]     cfg_wdata;

    rxf_in_if  rx_in ();
    rxf_out_if rx_out ();

    // Predictor state
    logic [rxf_pkg::BYTE_W-1:0]     ring_bytes [RING_DEPTH];
    logic [7:0]                     wr_ptr_m     = '0;
    logic [7:0]                     rd_ptr_m     = '0;
    logic [rxf_pkg::LEVEL_W-1:0]    seen_level   = '0;
    logic [rxf_pkg::TIME_W-1:0]     idle_cnt     = '0;
    logic                           frame_seen   = 1'b0;
    logic [rxf_pkg::TIME_W-1:0]     idle_limit_m = rxf_pkg::IDLE_LIMIT_RST;

    t_rx_result          pending_results [$];
    int unsigned         sent_items     = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;
    bit                  steady_flow    = 1'b0;

    rx_fifo_with_idle_frame_detect_unit #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (rx_in),
        .o_out       (rx_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [rxf_pkg::LEVEL_W-1:0] fifo_level();
        return wr_ptr_m - rd_ptr_m;
    endfunction

    // Apply one action to the predictor state and return its result
    function automatic t_rx_result predict_rx_result(rxf_pkg::t_action act,
                                                     logic [rxf_pkg::BYTE_W-1:0] data,
                                                     logic [rxf_pkg::TIME_W-1:0] el);
        t_rx_result                     r;
        logic [rxf_pkg::TIME_W:0]       sum;
        logic [rxf_pkg::LEVEL_W-1:0]    lvl;
        r   = NO_RES;
        lvl = fifo_level();
        case (act)
            rxf_pkg::ACT_PUSH: begin
                if (lvl >= RING_DEPTH) begin
                    r.status = rxf_pkg::ST_FULL;
                end else begin
                    ring_bytes[wr_ptr_m % RING_DEPTH] = data;
                    wr_ptr_m = wr_ptr_m + 8'd1;
                end
            end
            rxf_pkg::ACT_POP: begin
                if (lvl == 0) begin
                    r.status = rxf_pkg::ST_EMPTY;
                end else begin
                    r.byte_out = ring_bytes[rd_ptr_m % RING_DEPTH];
                    rd_ptr_m = rd_ptr_m + 8'd1;
                end
            end
            rxf_pkg::ACT_FLUSH: rd_ptr_m = wr_ptr_m;
            rxf_pkg::ACT_TICK: begin
                if (lvl == 0) begin
                    seen_level = '0;
                end else if (lvl != seen_level) begin
                    seen_level = lvl;
                    idle_cnt   = '0;
                end else if (idle_cnt < idle_limit_m) begin
                    // saturating add, flag once the limit is reached
                    sum      = {1'b0, idle_cnt} + {1'b0, el};
                    idle_cnt = sum[rxf_pkg::TIME_W] ? rxf_pkg::COUNT_MAX
                                                    : sum[rxf_pkg::TIME_W-1:0];
                    if (idle_cnt >= idle_limit_m)
                        frame_seen = 1'b1;
                end
            end
            rxf_pkg::ACT_ACK: frame_seen = 1'b0;
            default: ;
        endcase
        r.fill_level  = fifo_level();
        r.frame_ready = frame_seen;
        return r;
    endfunction

    // Elapsed times mostly at or below the current limit
    function automatic logic [rxf_pkg::TIME_W-1:0] pick_elapsed();
        case ($urandom_range(0, 3))
            0:       return rxf_pkg::TIME_W'($urandom_range(0, 32'(idle_limit_m) / 4));
            1, 2:    return rxf_pkg::TIME_W'($urandom_range(0, 32'(idle_limit_m)));
            default: return rxf_pkg::TIME_W'($urandom);
        endcase
    endfunction

    // Drive one action, wait for its transfer, queue the expected result
    task automatic send_action(input rxf_pkg::t_action act,
                               input logic [rxf_pkg::BYTE_W-1:0] data,
                               input logic [rxf_pkg::TIME_W-1:0] el, input bit typed,
                               input t_rx_result want);
        t_rx_result  predicted;
        if (!steady_flow && $urandom_range(0, 99) < 15) begin
            rx_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_in.valid   <= 1'b1;
        rx_in.action  <= act;
        rx_in.byte_in <= data;
        rx_in.elapsed <= el;
        do @(posedge i_clk); while (rx_in.ready !== 1'b1);
        predicted = predict_rx_result(act, data, el);
        pending_results.push_back(typed ? want : predicted);
        sent_items++;
    endtask

    // Stop sending and wait until every result is back
    task automatic drain_results();
        rx_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [rxf_pkg::TIME_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        idle_limit_m  = value;
    endtask

    // Mostly well-formed frames (burst, idle ticks, ack, drain), some noise
    task automatic run_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned burst;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140)
                                                    : $urandom_range(1, 24);
                repeat (burst) begin
                    send_action(rxf_pkg::ACT_PUSH, rxf_pkg::BYTE_W'($urandom),
                                rxf_pkg::TIME_W'($urandom), 1'b0, NO_RES);
                    if ($urandom_range(0, 4) == 0)
                        send_action(rxf_pkg::ACT_TICK, rxf_pkg::BYTE_W'($urandom),
                                    pick_elapsed(), 1'b0, NO_RES);
                end
                repeat ($urandom_range(1, 6))
                    send_action(rxf_pkg::ACT_TICK, rxf_pkg::BYTE_W'($urandom),
                                pick_elapsed(), 1'b0, NO_RES);
                if ($urandom_range(0, 3) != 0)
                    send_action(rxf_pkg::ACT_ACK, rxf_pkg::BYTE_W'($urandom),
                                rxf_pkg::TIME_W'($urandom), 1'b0, NO_RES);
                if ($urandom_range(0, 6) == 0) begin
                    send_action(rxf_pkg::ACT_FLUSH, rxf_pkg::BYTE_W'($urandom),
                                rxf_pkg::TIME_W'($urandom), 1'b0, NO_RES);
                end else begin
                    repeat ($urandom_range(0, 32'(fifo_level()) + 2))
                        send_action(rxf_pkg::ACT_POP, rxf_pkg::BYTE_W'($urandom),
                                    rxf_pkg::TIME_W'($urandom), 1'b0, NO_RES);
                end
            end else begin
                send_action(rxf_pkg::t_action'($urandom_range(0, 4)),
                            rxf_pkg::BYTE_W'($urandom), rxf_pkg::TIME_W'($urandom),
                            1'b0, NO_RES);
            end
        end
    endtask

    // Result checker and random sink stalls
    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n === 1'b1 && rx_out.valid === 1'b1 && rx_out.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d byte_out %0d fill_level %0d",
                       rx_out.status, rx_out.byte_out, rx_out.fill_level);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (rx_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rx_out.status);
                    mismatch_count++;
                end
                if (rx_out.byte_out !== want.byte_out) begin
                    $error("byte_out: expected %0d, got %0d", want.byte_out, rx_out.byte_out);
                    mismatch_count++;
                end
                if (rx_out.fill_level !== want.fill_level) begin
                    $error("fill_level: expected %0d, got %0d",
                           want.fill_level, rx_out.fill_level);
                    mismatch_count++;
                end
                if (rx_out.frame_ready !== want.frame_ready) begin
                    $error("frame_ready: expected %0d, got %0d",
                           want.frame_ready, rx_out.frame_ready);
                    mismatch_count++;
                end
            end
        end
        rx_out.ready <= steady_flow || ($urandom_range(0, 99) >= 25);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_in.valid   <= 1'b0;
        rx_in.action  <= rxf_pkg::ACT_PUSH;
        rx_in.byte_in <= '0;
        rx_in.elapsed <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset limit
        foreach (dir_rows[r])
            for (int unsigned k = 0; k < dir_rows[r].reps; k++)
                send_action(dir_rows[r].act, dir_rows[r].data + rxf_pkg::BYTE_W'(k),
                            dir_rows[r].el, dir_rows[r].typed, dir_rows[r].res);

        // Random phases, limit changed only while idle
        drain_results();
        write_idle_limit(16'd1);
        run_traffic(250);

        drain_results();
        write_idle_limit(16'hFFFF);
        run_traffic(250);

        drain_results();
        write_idle_limit(rxf_pkg::TIME_W'($urandom_range(1, 65535)));
        steady_flow = 1'b1;
        run_traffic(300);
        steady_flow = 1'b0;

        drain_results();
        write_idle_limit(rxf_pkg::IDLE_LIMIT_RST);
        run_traffic(300);

        drain_results();
        write_idle_limit(rxf_pkg::TIME_W'($urandom_range(2, 200)));
        run_traffic(370);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
